// ----- rtl/core/drm_pkg.sv -----
// ----------------------------------------------------------------------------
// drm_pkg
// Shared types, widths and constants of the distortion remap coordinate
// generator: configuration layout, inter-segment payloads and saturation.
// ----------------------------------------------------------------------------
package drm_pkg;

  // field widths
  localparam int unsigned PIX_W   = 12;
  localparam int unsigned SRC_W   = 24;
  localparam int unsigned CFG_W   = 60;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned COEF_W  = 20;

  // exact floor division by 125 through a reciprocal multiply
  localparam logic [28:0] RECIP_125   = 29'd274877907;
  localparam int unsigned RECIP_SHIFT = 35;
  // bias that keeps 12*xd + 62 nonnegative, a multiple of 125
  localparam logic signed [31:0] DIV_BIAS   = 32'sd131072000;
  localparam logic signed [26:0] DIV_UNBIAS = 27'sd1048576;

  // register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_K1     = 3'd0,
    REG_K2     = 3'd1,
    REG_K3     = 3'd2,
    REG_P1     = 3'd3,
    REG_P2     = 3'd4,
    REG_CENTER = 3'd5,
    REG_RES_X  = 3'd6,
    REG_RES_Y  = 3'd7
  } drm_reg_e;

  // configuration as seen by the datapath
  typedef struct packed {
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] k3;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
    logic [15:0]        cx;
    logic [15:0]        cy;
    logic [CFG_W-1:0]   res_x;
    logic [CFG_W-1:0]   res_y;
  } drm_cfg_t;

  // offsets and second-order terms
  typedef struct packed {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic [28:0]        xx;
    logic [28:0]        yy;
    logic signed [29:0] xy;
    logic [29:0]        r2;
  } drm_geom_t;

  // distorted offsets, Q19.4
  typedef struct packed {
    logic signed [23:0] xd;
    logic signed [23:0] yd;
    logic               clip;
  } drm_dist_t;

  // saturate to signed 32 bits
  function automatic logic signed [31:0] sat_s32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sh007FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -40'sh0080000000) begin
      r = -32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // overflow of signed 24 bits
  function automatic logic ovf_s24(input logic signed [47:0] v);
    return (v > 48'sh7FFFFF) || (v < -48'sh800000);
  endfunction

  // saturate to signed 24 bits
  function automatic logic signed [23:0] sat_s24(input logic signed [47:0] v);
    logic signed [23:0] r;
    if (v > 48'sh7FFFFF) begin
      r = 24'sh7FFFFF;
    end else if (v < -48'sh800000) begin
      r = -24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/drm_if.sv -----
// ----------------------------------------------------------------------------
// drm channel interfaces
// Valid/ready channels for pixel positions in and source coordinates out.
// ----------------------------------------------------------------------------
interface drm_pix_if;
  import drm_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_col;
  logic [PIX_W-1:0] pixel_row;

  modport source (output valid, pixel_col, pixel_row, input ready);
  modport sink   (input valid, pixel_col, pixel_row, output ready);
endinterface

interface drm_src_if;
  import drm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SRC_W-1:0] source_x;
  logic signed [SRC_W-1:0] source_y;
  logic                    clipped;

  modport source (output valid, source_x, source_y, clipped, input ready);
  modport sink   (input valid, source_x, source_y, clipped, output ready);
endinterface

// ----- rtl/core/distortion_remap_coordinate_generator_unit.sv -----
// ----------------------------------------------------------------------------
// distortion_remap_coordinate_generator_unit
// Maps an output pixel position to its distorted source coordinate.
//
//   channel  dir  handshake    payload
//   pix_i    in   valid/ready  pixel_col, pixel_row
//   src_o    out  valid/ready  source_x, source_y, clipped
//   cfg      in   cfg_we_i     cfg_idx_i, cfg_wdata_i
//
// twelve register stages, one pixel per cycle unless the output stalls
// the longest stage holds one 32x31 multiply of the radial Horner step
// each stage has its own valid bit and moves when empty or when the next
// stage moves, so bubbles are absorbed and a stalled output holds its data
// reset clears valid bits and configuration, no clearing pass
// ----------------------------------------------------------------------------
module distortion_remap_coordinate_generator_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  drm_pix_if.sink                   pix_i,
  drm_src_if.source                 src_o,
  input  logic                      cfg_we_i,
  input  logic [drm_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [drm_pkg::CFG_W-1:0] cfg_wdata_i
);
  import drm_pkg::*;

  // configuration registers
  drm_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (drm_reg_e'(cfg_idx_i))
        REG_K1:     cfg_q.k1 <= cfg_wdata_i[31:0];
        REG_K2:     cfg_q.k2 <= cfg_wdata_i[31:0];
        REG_K3:     cfg_q.k3 <= cfg_wdata_i[31:0];
        REG_P1:     cfg_q.p1 <= cfg_wdata_i[31:0];
        REG_P2:     cfg_q.p2 <= cfg_wdata_i[31:0];
        REG_CENTER: begin
          cfg_q.cx <= cfg_wdata_i[15:0];
          cfg_q.cy <= cfg_wdata_i[31:16];
        end
        REG_RES_X:  cfg_q.res_x <= cfg_wdata_i;
        REG_RES_Y:  cfg_q.res_y <= cfg_wdata_i;
        default:    cfg_q <= cfg_q;
      endcase
    end
  end

  // segment links
  logic      g_valid, g_ready, d_valid, d_ready;
  drm_geom_t geom;
  drm_dist_t dist_link;

  drm_geom u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .col_i       (pix_i.pixel_col),
    .row_i       (pix_i.pixel_row),
    .out_valid_o (g_valid),
    .out_ready_i (g_ready),
    .out_o       (geom)
  );

  drm_poly u_poly (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (g_valid),
    .in_ready_o  (g_ready),
    .in_i        (geom),
    .out_valid_o (d_valid),
    .out_ready_i (d_ready),
    .out_o       (dist_link)
  );

  drm_resid u_resid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (d_valid),
    .in_ready_o  (d_ready),
    .in_i        (dist_link),
    .out_valid_o (src_o.valid),
    .out_ready_i (src_o.ready),
    .source_x_o  (src_o.source_x),
    .source_y_o  (src_o.source_y),
    .clipped_o   (src_o.clipped)
  );

endmodule

// ----- rtl/core/drm_geom.sv -----
// ----------------------------------------------------------------------------
// drm_geom
// Two-stage segment: offset from the optical center, then squares and cross
// product rounded to Q.4.
// ----------------------------------------------------------------------------
module drm_geom (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  drm_pkg::drm_cfg_t         cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [drm_pkg::PIX_W-1:0] col_i,
  input  logic [drm_pkg::PIX_W-1:0] row_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output drm_pkg::drm_geom_t        out_o
);
  import drm_pkg::*;

  localparam int unsigned NS = 2;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  // stall chain, a stage moves when empty or when the next one moves
  always_comb begin
    en[NS-1] = ~v_q[NS-1] | out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

  // stage 1: centered offset, Q.4 pixels
  logic signed [17:0] x_d, y_d, x_q, y_q;
  assign x_d = $signed({2'b00, col_i, 4'b0000}) - $signed({2'b00, cfg_i.cx});
  assign y_d = $signed({2'b00, row_i, 4'b0000}) - $signed({2'b00, cfg_i.cy});

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  // stage 2: rounded products
  logic signed [35:0] pxx, pyy, pxy, rxx, ryy, rxy;
  drm_geom_t          g_d, g_q;

  always_comb begin
    pxx    = x_q * x_q;
    pyy    = y_q * y_q;
    pxy    = x_q * y_q;
    rxx    = (pxx + 36'sd8) >>> 4;
    ryy    = (pyy + 36'sd8) >>> 4;
    rxy    = (pxy + 36'sd8) >>> 4;
    g_d.x  = x_q;
    g_d.y  = y_q;
    g_d.xx = rxx[28:0];
    g_d.yy = ryy[28:0];
    g_d.xy = rxy[29:0];
    g_d.r2 = {1'b0, rxx[28:0]} + {1'b0, ryy[28:0]};
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) g_q <= g_d;
  end

  assign out_o = g_q;

endmodule

// ----- rtl/core/drm_poly.sv -----
// ----------------------------------------------------------------------------
// drm_poly
// Five-stage segment: Horner evaluation of the radial polynomial, tangential
// terms, scaling of the offset and clamp of the distorted offset.
// ----------------------------------------------------------------------------
module drm_poly (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  drm_pkg::drm_cfg_t  cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  drm_pkg::drm_geom_t in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output drm_pkg::drm_dist_t out_o
);
  import drm_pkg::*;

  localparam int unsigned NS = 5;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  // stall chain
  always_comb begin
    en[NS-1] = ~v_q[NS-1] | out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

  // stage 1: first Horner step and raw tangential products
  logic signed [30:0] r2s, qx, qy;
  logic signed [62:0] pk3, rk3;
  logic signed [39:0] s2;
  logic signed [17:0] x1_q, y1_q;
  logic [29:0]        r21_q;
  logic signed [31:0] a2_q;
  logic signed [61:0] t1x_q, t2y_q;
  logic signed [62:0] t2x_q, t1y_q;

  always_comb begin
    r2s = $signed({1'b0, in_i.r2});
    qx  = r2s + $signed({1'b0, in_i.xx, 1'b0});
    qy  = r2s + $signed({1'b0, in_i.yy, 1'b0});
    pk3 = cfg_i.k3 * r2s;
    rk3 = (pk3 + 63'sh800000) >>> 24;
    s2  = cfg_i.k2 + $signed(rk3[39:0]);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      x1_q  <= in_i.x;
      y1_q  <= in_i.y;
      r21_q <= in_i.r2;
      a2_q  <= sat_s32(s2);
      t1x_q <= cfg_i.p1 * in_i.xy;
      t2x_q <= cfg_i.p2 * qx;
      t1y_q <= cfg_i.p1 * qy;
      t2y_q <= cfg_i.p2 * in_i.xy;
    end
  end

  // stage 2: second Horner step, tangential sums (cross terms carry the factor 2)
  logic signed [30:0] r2s2;
  logic signed [62:0] pa2, ra2;
  logic signed [39:0] s1;
  logic signed [61:0] rt1x, rt2y;
  logic signed [62:0] rt2x, rt1y;
  logic signed [39:0] tx, ty, rtx, rty;
  logic signed [17:0] x2_q, y2_q;
  logic [29:0]        r22_q;
  logic signed [31:0] a1_q;
  logic signed [29:0] tdx2_q, tdy2_q;

  always_comb begin
    r2s2 = $signed({1'b0, r21_q});
    pa2  = a2_q * r2s2;
    ra2  = (pa2 + 63'sh800000) >>> 24;
    s1   = cfg_i.k1 + $signed(ra2[39:0]);
    rt1x = (t1x_q + 62'sh400000) >>> 23;
    rt2x = (t2x_q + 63'sh800000) >>> 24;
    rt1y = (t1y_q + 63'sh800000) >>> 24;
    rt2y = (t2y_q + 62'sh400000) >>> 23;
    tx   = $signed(rt1x[39:0]) + $signed(rt2x[39:0]);
    ty   = $signed(rt1y[39:0]) + $signed(rt2y[39:0]);
    rtx  = (tx + 40'sd512) >>> 10;
    rty  = (ty + 40'sd512) >>> 10;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      x2_q   <= x1_q;
      y2_q   <= y1_q;
      r22_q  <= r21_q;
      a1_q   <= sat_s32(s1);
      tdx2_q <= rtx[29:0];
      tdy2_q <= rty[29:0];
    end
  end

  // stage 3: radial gain, Q.24
  logic signed [62:0] pa1, ra1;
  logic signed [38:0] rad_d, rad_q;
  logic signed [17:0] x3_q, y3_q;
  logic signed [29:0] tdx3_q, tdy3_q;

  always_comb begin
    pa1   = a1_q * $signed({1'b0, r22_q});
    ra1   = (pa1 + 63'sh800000) >>> 24;
    rad_d = $signed(ra1[38:0]) + 39'sh1000000;
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      rad_q  <= rad_d;
      x3_q   <= x2_q;
      y3_q   <= y2_q;
      tdx3_q <= tdx2_q;
      tdy3_q <= tdy2_q;
    end
  end

  // stage 4: offset times radial gain
  logic signed [56:0] prx_q, pry_q;
  logic signed [29:0] tdx4_q, tdy4_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      prx_q  <= x3_q * rad_q;
      pry_q  <= y3_q * rad_q;
      tdx4_q <= tdx3_q;
      tdy4_q <= tdy3_q;
    end
  end

  // stage 5: add tangential part and clamp to Q19.4
  logic signed [56:0] rrx, rry;
  logic signed [47:0] sxd, syd;
  drm_dist_t          d_d, d_q;

  always_comb begin
    rrx    = (prx_q + 57'sh800000) >>> 24;
    rry    = (pry_q + 57'sh800000) >>> 24;
    sxd    = $signed(rrx[47:0]) + tdx4_q;
    syd    = $signed(rry[47:0]) + tdy4_q;
    d_d.xd = sat_s24(sxd);
    d_d.yd = sat_s24(syd);
    d_d.clip = ovf_s24(sxd) | ovf_s24(syd);
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) d_q <= d_d;
  end

  assign out_o = d_q;

endmodule

// ----- rtl/core/drm_resid.sv -----
// ----------------------------------------------------------------------------
// drm_resid
// Five-stage segment: scale by 4096/1000, quadratic residual, center add and
// output saturation. The last stage is the output register.
// ----------------------------------------------------------------------------
module drm_resid (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  drm_pkg::drm_cfg_t                cfg_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  drm_pkg::drm_dist_t               in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [drm_pkg::SRC_W-1:0] source_x_o,
  output logic signed [drm_pkg::SRC_W-1:0] source_y_o,
  output logic                             clipped_o
);
  import drm_pkg::*;

  localparam int unsigned NS = 5;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  // stall chain
  always_comb begin
    en[NS-1] = ~v_q[NS-1] | out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

  // carried distorted offsets
  drm_dist_t d1_q, d2_q, d3_q, d4_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) d1_q <= in_i;
    if (en[1]) d2_q <= d1_q;
    if (en[2]) d3_q <= d2_q;
    if (en[3]) d4_q <= d3_q;
  end

  // stage 1: floor((12*xd + 62)/125) by biased reciprocal multiply
  logic signed [31:0] xw, yw, tx, ty;
  logic [56:0]        pux_q, puy_q;

  always_comb begin
    xw = 32'(in_i.xd);
    yw = 32'(in_i.yd);
    tx = (xw <<< 3) + (xw <<< 2) + 32'sd62 + DIV_BIAS;
    ty = (yw <<< 3) + (yw <<< 2) + 32'sd62 + DIV_BIAS;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      pux_q <= tx[27:0] * RECIP_125;
      puy_q <= ty[27:0] * RECIP_125;
    end
  end

  // stage 2: xn = 4*xd + quotient, Q.16 of the offset over 1000
  logic [21:0]        qx, qy;
  logic signed [26:0] xn_d, yn_d, xn_q, yn_q;

  always_comb begin
    qx   = pux_q[RECIP_SHIFT +: 22];
    qy   = puy_q[RECIP_SHIFT +: 22];
    xn_d = $signed({d1_q.xd, 2'b00}) + $signed({5'b00000, qx}) - DIV_UNBIAS;
    yn_d = $signed({d1_q.yd, 2'b00}) + $signed({5'b00000, qy}) - DIV_UNBIAS;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      xn_q <= xn_d;
      yn_q <= yn_d;
    end
  end

  // stage 3: second-order monomials
  logic signed [53:0] pb0, pb1, pb2, rb0, rb1, rb2;
  logic signed [36:0] b0_q, b1_q, b2_q;

  always_comb begin
    pb0 = xn_q * xn_q;
    pb1 = xn_q * yn_q;
    pb2 = yn_q * yn_q;
    rb0 = (pb0 + 54'sh8000) >>> 16;
    rb1 = (pb1 + 54'sh8000) >>> 16;
    rb2 = (pb2 + 54'sh8000) >>> 16;
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      b0_q <= rb0[36:0];
      b1_q <= rb1[36:0];
      b2_q <= rb2[36:0];
    end
  end

  // stage 4: coefficient products
  logic signed [COEF_W-1:0] cx0, cx1, cx2, cy0, cy1, cy2;
  logic signed [56:0]       px0_q, px1_q, px2_q, py0_q, py1_q, py2_q;

  always_comb begin
    cx0 = $signed(cfg_i.res_x[0*COEF_W +: COEF_W]);
    cx1 = $signed(cfg_i.res_x[1*COEF_W +: COEF_W]);
    cx2 = $signed(cfg_i.res_x[2*COEF_W +: COEF_W]);
    cy0 = $signed(cfg_i.res_y[0*COEF_W +: COEF_W]);
    cy1 = $signed(cfg_i.res_y[1*COEF_W +: COEF_W]);
    cy2 = $signed(cfg_i.res_y[2*COEF_W +: COEF_W]);
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      px0_q <= cx0 * b0_q;
      px1_q <= cx1 * b1_q;
      px2_q <= cx2 * b2_q;
      py0_q <= cy0 * b0_q;
      py1_q <= cy1 * b1_q;
      py2_q <= cy2 * b2_q;
    end
  end

  // stage 5: residual, center add back, saturate to Q17.6
  logic signed [58:0] sumx, sumy, rsx, rsy;
  logic signed [47:0] fx, fy;
  logic signed [SRC_W-1:0] sx_q, sy_q;
  logic                    clip_q;

  always_comb begin
    sumx = px0_q + px1_q + px2_q;
    sumy = py0_q + py1_q + py2_q;
    rsx  = (sumx + 59'sh80000) >>> 20;
    rsy  = (sumy + 59'sh80000) >>> 20;
    fx   = $signed({d4_q.xd, 2'b00}) + $signed(rsx[47:0])
         + $signed({30'd0, cfg_i.cx, 2'b00});
    fy   = $signed({d4_q.yd, 2'b00}) + $signed(rsy[47:0])
         + $signed({30'd0, cfg_i.cy, 2'b00});
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      sx_q   <= sat_s24(fx);
      sy_q   <= sat_s24(fy);
      clip_q <= d4_q.clip | ovf_s24(fx) | ovf_s24(fy);
    end
  end

  assign source_x_o = sx_q;
  assign source_y_o = sy_q;
  assign clipped_o  = clip_q;

endmodule

// ----- tb/tb_distortion_remap_coordinate_generator_unit.sv -----
// ----------------------------------------------------------------------------
// tb_distortion_remap_coordinate_generator_unit
// Self-checking bench for the distortion remap coordinate generator. Pixel
// positions go in through a valid/ready channel with random gaps. Source
// coordinates are checked in order against a bit-exact fixed-point predictor.
// The configuration is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_distortion_remap_coordinate_generator_unit;
  import drm_pkg::*;

  // one predicted source coordinate
  typedef struct {
    logic signed [SRC_W-1:0] sx;
    logic signed [SRC_W-1:0] sy;
    logic                    clip;
  } coord_t;

  // coordinate predictor and in-order checker
  class coord_board;
    logic [CFG_W-1:0] regs [8];
    coord_t           coord_due [$];
    int               fails;

    function new();
      foreach (regs[i]) regs[i] = '0;
      fails = 0;
    endfunction

    // register write as the block sees it
    function void write_reg(drm_reg_e idx, logic [CFG_W-1:0] val);
      if (idx < REG_RES_X) regs[idx] = {28'd0, val[31:0]};
      else                 regs[idx] = val;
    endfunction

    // round to nearest, halves up
    function longint rnd(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function longint sat(longint v, int w, inout bit flag);
      longint hi, lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
        flag = 1;
        return hi;
      end
      if (v < lo) begin
        flag = 1;
        return lo;
      end
      return v;
    endfunction

    // round(v * 4096 / 1000) by floor division
    function longint scale_norm(longint v);
      longint n, q;
      n = v * 8192 + 1000;
      q = n / 2000;
      if ((n % 2000 != 0) && (n < 0)) q = q - 1;
      return q;
    endfunction

    function longint poly(logic [CFG_W-1:0] row, longint b0, longint b1, longint b2);
      longint c0, c1, c2;
      c0 = longint'($signed(row[19:0]));
      c1 = longint'($signed(row[39:20]));
      c2 = longint'($signed(row[59:40]));
      return rnd(c0 * b0 + c1 * b1 + c2 * b2, 20);
    endfunction

    // accepted pixel: predict its source coordinate
    function void note_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
      longint k1, k2, k3, p1, p2, cx, cy, x, y, xx, yy, xy, r2, a, radial;
      longint xr, yr, tx, ty, xd, yd, xn, yn, b0, b1, b2, sx, sy;
      bit     dummy, clip;
      coord_t c;
      k1 = longint'($signed(regs[REG_K1][31:0]));
      k2 = longint'($signed(regs[REG_K2][31:0]));
      k3 = longint'($signed(regs[REG_K3][31:0]));
      p1 = longint'($signed(regs[REG_P1][31:0]));
      p2 = longint'($signed(regs[REG_P2][31:0]));
      cx = longint'(regs[REG_CENTER][15:0]);
      cy = longint'(regs[REG_CENTER][31:16]);
      clip = 0;
      dummy = 0;
      x = longint'(col) * 16 - cx;
      y = longint'(row) * 16 - cy;
      xx = rnd(x * x, 4);
      yy = rnd(y * y, 4);
      xy = rnd(x * y, 4);
      r2 = xx + yy;
      // radial horner, inner saturation does not flag
      a = k3;
      a = sat(k2 + rnd(a * r2, 24), 32, dummy);
      a = sat(k1 + rnd(a * r2, 24), 32, dummy);
      radial = (longint'(1) <<< 24) + rnd(a * r2, 24);
      xr = rnd(x * radial, 24);
      yr = rnd(y * radial, 24);
      tx = rnd(2 * p1 * xy, 24) + rnd(p2 * (r2 + 2 * xx), 24);
      ty = rnd(p1 * (r2 + 2 * yy), 24) + rnd(2 * p2 * xy, 24);
      xd = sat(xr + rnd(tx, 10), 24, clip);
      yd = sat(yr + rnd(ty, 10), 24, clip);
      // quadratic residual on scaled offsets
      xn = scale_norm(xd);
      yn = scale_norm(yd);
      b0 = rnd(xn * xn, 16);
      b1 = rnd(xn * yn, 16);
      b2 = rnd(yn * yn, 16);
      sx = sat(4 * xd + poly(regs[REG_RES_X], b0, b1, b2) + 4 * cx, 24, clip);
      sy = sat(4 * yd + poly(regs[REG_RES_Y], b0, b1, b2) + 4 * cy, 24, clip);
      c.sx = sx[SRC_W-1:0];
      c.sy = sy[SRC_W-1:0];
      c.clip = clip;
      coord_due.push_back(c);
    endfunction

    // accepted result: compare with oldest prediction
    function void check_coord(logic signed [SRC_W-1:0] sx, logic signed [SRC_W-1:0] sy,
                              logic clip);
      coord_t c;
      if (coord_due.size() == 0) begin
        $error("source coordinate transfer with no pixel pending");
        fails++;
        return;
      end
      c = coord_due.pop_front();
      if (sx !== c.sx) begin
        $error("source_x expected %0d got %0d", c.sx, sx);
        fails++;
      end
      if (sy !== c.sy) begin
        $error("source_y expected %0d got %0d", c.sy, sy);
        fails++;
      end
      if (clip !== c.clip) begin
        $error("clipped expected %0d got %0d", c.clip, clip);
        fails++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;
  bit               quiet;

  drm_pix_if pix ();
  drm_src_if src ();

  coord_board board = new();

  distortion_remap_coordinate_generator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_i       (pix),
    .src_o       (src),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // clock
  initial clk_i = 0;
  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  // random gap, mostly short, a few long
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side stalls
  int stall_left;
  initial begin
    src.ready = 0;
    stall_left = 0;
  end
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      src.ready <= 0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(7) == 0) begin
      src.ready <= 0;
      stall_left <= pick_gap();
    end else begin
      src.ready <= 1;
    end
  end

  // monitor both transfers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (src.valid && src.ready) board.check_coord(src.source_x, src.source_y, src.clipped);
      if (pix.valid && pix.ready) board.note_pixel(pix.pixel_col, pix.pixel_row);
    end
  end

  // one pixel transfer
  task automatic send_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix.valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    pix.valid     <= 1;
    pix.pixel_col <= col;
    pix.pixel_row <= row;
    do @(posedge clk_i); while (!pix.ready);
  endtask

  // wait until the pipeline is empty
  task automatic drain();
    pix.valid <= 0;
    @(posedge clk_i);
    while (board.coord_due.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  // one register write, then the write enable is taken low again
  task automatic write_reg(drm_reg_e idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    board.write_reg(idx, val);
    cfg_we <= 0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_coef(int mode);
    case (mode)
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
      default: return $urandom();
    endcase
  endfunction

  // full register setting for one phase
  task automatic set_phase(int mode);
    logic [CFG_W-1:0] res;
    drain();
    for (int i = 0; i < 5; i++) begin
      write_reg(drm_reg_e'(i), CFG_W'({$urandom(), pick_coef(mode)}));
    end
    case (mode)
      0: write_reg(REG_CENTER, CFG_W'({$urandom(), 32'hFFFFFFFF}));
      1: write_reg(REG_CENTER, 60'd0);
      default: write_reg(REG_CENTER, CFG_W'({$urandom(), $urandom_range(0, 65535),
                                              16'($urandom_range(0, 65535))}));
    endcase
    for (int i = 6; i < 8; i++) begin
      res = CFG_W'({$urandom(), $urandom()});
      if (mode == 0) res = {CFG_W{1'b1}} >> 1 | (res & 60'h0);
      if (mode == 1) res = {20'h80000, 20'h80000, 20'h80000};
      if (mode == 2) res = {8'd0, res[51:0]} ^ {3{res[59], res[59], 18'd0}};
      write_reg(drm_reg_e'(i), res);
    end
  endtask

  task automatic directed_set();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'd0, 12'hFFF);
    send_pixel(12'hFFF, 12'd0);
    send_pixel(board.regs[REG_CENTER][15:4], board.regs[REG_CENTER][31:20]);
    send_pixel(12'hAAA, 12'h555);
  endtask

  task automatic random_items(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) send_pixel(12'($urandom()), 12'($urandom()));
      else send_pixel(12'($urandom_range(0, 2047)), 12'($urandom_range(0, 2047)));
    end
  endtask

  // main sequence
  initial begin
    rst_ni        = 0;
    cfg_we        = 0;
    cfg_idx       = REG_K1;
    cfg_wdata     = '0;
    pix.valid     = 0;
    pix.pixel_col = '0;
    pix.pixel_row = '0;
    quiet         = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // registers at reset value
    directed_set();
    random_items(40);

    // extremes then typical and random settings
    for (int ph = 0; ph < 8; ph++) begin
      set_phase(ph % 4);
      if (ph < 3) directed_set();
      quiet = (ph == 5);
      random_items(35);
      // hold off until every result is out, then continue
      drain();
      random_items(35);
    end
    quiet = 0;

    drain();
    if (board.fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run limit
  initial begin
    #(8 * 1000000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
